// ===== rtl/log_bucket_histogram_defines.svh =====
// Assertion macros used by the histogram RTL.
`ifndef LOG_BUCKET_HISTOGRAM_DEFINES_SVH
`define LOG_BUCKET_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LBH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LBH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lbh_pkg.sv =====
// Types, constants and the bucket bound table of the log bucket histogram.
`default_nettype none

package lbh_pkg;

  localparam int DECADES   = 12;
  localparam int NREG      = 10 * DECADES;
  localparam int NCNT      = NREG + 1;
  localparam int LIN_MAX   = 10;
  localparam int BKT_W     = 7;
  localparam int VAL_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int NBOUNDS   = 121;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 392;

  localparam logic OP_ENTER = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LOG_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKETS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] count;
    logic [VAL_W-1:0] sum;
    logic [VAL_W-1:0] smallest;
    logic [VAL_W-1:0] largest;
    logic [VAL_W-1:0] over;
  } lbh_stats_t;

  localparam logic [VAL_W-1:0] BOUNDS [NBOUNDS] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8, 64'd9, 64'd10,
    64'd12, 64'd15, 64'd19, 64'd25, 64'd31, 64'd39, 64'd50, 64'd63, 64'd79, 64'd100,
    64'd125, 64'd158, 64'd199, 64'd251, 64'd316, 64'd398, 64'd501, 64'd630, 64'd794,
    64'd1000,
    64'd1258, 64'd1584, 64'd1995, 64'd2511, 64'd3162, 64'd3981, 64'd5011, 64'd6309,
    64'd7943, 64'd10000,
    64'd12589, 64'd15848, 64'd19952, 64'd25118, 64'd31622, 64'd39810, 64'd50118,
    64'd63095, 64'd79432, 64'd100000,
    64'd125892, 64'd158489, 64'd199526, 64'd251188, 64'd316227, 64'd398107,
    64'd501187, 64'd630957, 64'd794328, 64'd1000000,
    64'd1258925, 64'd1584893, 64'd1995262, 64'd2511886, 64'd3162277, 64'd3981071,
    64'd5011872, 64'd6309573, 64'd7943282, 64'd10000000,
    64'd12589254, 64'd15848931, 64'd19952623, 64'd25118864, 64'd31622776,
    64'd39810717, 64'd50118723, 64'd63095734, 64'd79432823, 64'd100000000,
    64'd125892541, 64'd158489319, 64'd199526231, 64'd251188643, 64'd316227766,
    64'd398107170, 64'd501187233, 64'd630957344, 64'd794328234, 64'd1000000000,
    64'd1258925411, 64'd1584893192, 64'd1995262314, 64'd2511886431, 64'd3162277660,
    64'd3981071705, 64'd5011872336, 64'd6309573444, 64'd7943282347, 64'd10000000000,
    64'd12589254117, 64'd15848931924, 64'd19952623149, 64'd25118864315,
    64'd31622776601, 64'd39810717055, 64'd50118723362, 64'd63095734448,
    64'd79432823472, 64'd100000000000,
    64'd125892541179, 64'd158489319246, 64'd199526231496, 64'd251188643150,
    64'd316227766016, 64'd398107170553, 64'd501187233627, 64'd630957344480,
    64'd794328234724, 64'd1000000000000
  };

endpackage

`default_nettype wire

// ===== rtl/log_bucket_histogram.sv =====
// Top level of the log bucket histogram: item pipeline, counter RAM and config.
//
// Input items arrive on in_*: tuser is the opcode (0 enters a sample, 1 reads
// one bucket counter), tdata carries sample and bucket_index. Each item gives
// one result item on out_* with the bucket number, that bucket's counter after
// the update, and the count, sum, min, max and over-limit count.
// An accepted item passes the compare stage, then bucket select and counter RAM
// read, then increment and write-back into the result register.
// One item is taken every cycle unless the pipeline holds for the output; the counter
// RAM takes one read and one write per cycle, with a bypass for the same bucket on adjacent items.
// When out_tready is low with a result waiting, the whole pipeline holds and
// in_tready drops in the same cycle.
// Reset clears config, summary values and the per-bucket valid bits at once;
// a bucket without its valid bit reads as zero, so no clearing pass is run.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, by the user only while
// idle (the block does not enforce this); writing sample_limit clears the over-limit count.
`default_nettype none

`include "log_bucket_histogram_defines.svh"

module log_bucket_histogram
  import lbh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,  // sample, bucket_index, zero pad
  input  wire logic                  in_tuser,  // opcode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // bucket_number, bucket_tally, sample_count, sample_sum, smallest, largest,
  // over_limit_count, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [VAL_W-1:0]      cfg_wdata
);

  logic             en;
  logic             lim_clr;
  logic             log_scale_r;
  logic [BKT_W-1:0] buckets_r;
  logic [VAL_W-1:0] limit_r;

  logic [VAL_W-1:0] in_sample;
  logic [BKT_W-1:0] in_idx;
  logic [NREG-1:0]  in_ge;

  logic             p1_valid_r;
  logic             p1_op_r;
  logic [VAL_W-1:0] p1_sample_r;
  logic [BKT_W-1:0] p1_idx_r;
  logic [NREG-1:0]  p1_ge_r;
  logic [NREG:0]    p1_ge_ext;
  logic [BKT_W-1:0] p1_n;
  logic [BKT_W-1:0] p1_cnt;
  logic [BKT_W-1:0] p1_log_bkt;
  logic [BKT_W-1:0] p1_lin_bkt;
  logic [BKT_W-1:0] p1_bkt;
  logic             p1_oor;
  logic [BKT_W-1:0] p1_raddr;

  logic             p2_valid_r;
  logic             p2_op_r;
  logic [VAL_W-1:0] p2_sample_r;
  logic [BKT_W-1:0] p2_bkt_r;
  logic             p2_oor_r;
  logic             p2_fwd_r;
  logic [VAL_W-1:0] p2_fwd_data_r;
  logic             p2_wr;
  logic [VAL_W-1:0] p2_base;
  logic [VAL_W-1:0] p2_tally;
  logic [VAL_W-1:0] ram_rdata;
  logic [NCNT-1:0]  cnt_vld_r;

  lbh_stats_t       stats_nxt;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign lim_clr    = cfg_we && (cfg_index == REG_SAMPLE_LIMIT);

  assign in_sample = in_tdata[VAL_W-1:0];
  assign in_idx    = in_tdata[VAL_W+BKT_W-1:VAL_W];

  always_comb begin
    for (int k = 0; k < NREG; k++) begin
      in_ge[k] = BOUNDS[k+1] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_scale_r <= 1'b0;
      buckets_r   <= '0;
      limit_r     <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_LOG_SCALE) begin
        log_scale_r <= cfg_wdata[0];
      end
      if (cfg_index == REG_BUCKETS) begin
        buckets_r <= cfg_wdata[BKT_W-1:0];
      end
      if (cfg_index == REG_SAMPLE_LIMIT) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // bucket select: bounds compare as a thermometer, its top edge is the count
  always_comb begin
    p1_n      = (buckets_r > BKT_W'(NREG)) ? BKT_W'(NREG) : buckets_r;
    p1_ge_ext = {1'b0, p1_ge_r};
    p1_cnt    = '0;
    for (int k = 0; k < NREG; k++) begin
      if (p1_ge_ext[k] && !p1_ge_ext[k+1]) begin
        p1_cnt = p1_cnt | BKT_W'(k + 1);
      end
    end
    p1_log_bkt = (p1_cnt < p1_n) ? p1_cnt : p1_n;
    p1_lin_bkt = (p1_sample_r[VAL_W-1:BKT_W] == '0 && p1_sample_r[BKT_W-1:0] < p1_n)
                 ? p1_sample_r[BKT_W-1:0] : p1_n;
    if (p1_op_r == OP_READ) begin
      p1_bkt = p1_idx_r;
    end else if (log_scale_r && p1_n > BKT_W'(LIN_MAX)) begin
      p1_bkt = p1_log_bkt;
    end else begin
      p1_bkt = p1_lin_bkt;
    end
    p1_oor   = (p1_op_r == OP_READ) && (p1_idx_r > BKT_W'(NREG));
    p1_raddr = p1_oor ? '0 : p1_bkt;
  end

  lbh_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NCNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (en && p2_wr),
    .waddr (p2_bkt_r),
    .wdata (p2_tally),
    .re    (en),
    .raddr (p1_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    p2_wr = p2_valid_r && (p2_op_r == OP_ENTER);
    if (p2_fwd_r) begin
      p2_base = p2_fwd_data_r;
    end else if (p2_oor_r || !cnt_vld_r[p2_bkt_r]) begin
      p2_base = '0;
    end else begin
      p2_base = ram_rdata;
    end
    p2_tally = (p2_op_r == OP_ENTER) ? p2_base + VAL_W'(1) : p2_base;
  end

  lbh_stats u_stats (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (en && p2_wr),
    .sample       (p2_sample_r),
    .lim_clr      (lim_clr),
    .sample_limit (limit_r),
    .stats_nxt    (stats_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p2_fwd_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_vld_r   <= '0;
    end else if (en) begin
      p1_valid_r  <= in_tvalid;
      p2_valid_r  <= p1_valid_r;
      p2_fwd_r    <= p1_valid_r && p2_wr && (p1_bkt == p2_bkt_r);
      out_valid_r <= p2_valid_r;
      if (p2_wr) begin
        cnt_vld_r[p2_bkt_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_op_r       <= in_tuser;
      p1_sample_r   <= in_sample;
      p1_idx_r      <= in_idx;
      p1_ge_r       <= in_ge;
      p2_op_r       <= p1_op_r;
      p2_sample_r   <= p1_sample_r;
      p2_bkt_r      <= p1_bkt;
      p2_oor_r      <= p1_oor;
      p2_fwd_data_r <= p2_tally;
      out_data_r    <= {1'b0, stats_nxt.over, stats_nxt.largest, stats_nxt.smallest,
                        stats_nxt.sum, stats_nxt.count, p2_tally, p2_bkt_r};
    end
  end

  `LBH_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, p1_valid_r, "accepted item lost")
  `LBH_ASSERT_NOW(a_bucket_range, p2_wr, p2_bkt_r <= BKT_W'(NREG), "bucket out of range")
  `LBH_ASSERT_NEXT(a_vld_set, en && p2_wr, cnt_vld_r[$past(p2_bkt_r)], "valid bit not set")

endmodule

`default_nettype wire

// ===== rtl/lbh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lbh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lbh_stats.sv =====
// Summary registers: sample count, sum, min, max and over-limit count.
`default_nettype none

module lbh_stats
  import lbh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             upd,
  input  wire logic [VAL_W-1:0] sample,
  input  wire logic             lim_clr,
  input  wire logic [VAL_W-1:0] sample_limit,
  output lbh_stats_t            stats_nxt
);

  lbh_stats_t stats_r;

  always_comb begin
    stats_nxt = stats_r;
    if (upd) begin
      stats_nxt.count = stats_r.count + VAL_W'(1);
      stats_nxt.sum   = stats_r.sum + sample;
      if (sample < stats_r.smallest) begin
        stats_nxt.smallest = sample;
      end
      if (sample > stats_r.largest) begin
        stats_nxt.largest = sample;
      end
      if (sample_limit != '0 && sample > sample_limit) begin
        stats_nxt.over = stats_r.over + VAL_W'(1);
      end
    end
    if (lim_clr) begin
      stats_nxt.over = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r.count    <= '0;
      stats_r.sum      <= '0;
      stats_r.smallest <= '1;
      stats_r.largest  <= '0;
      stats_r.over     <= '0;
    end else begin
      stats_r <= stats_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_log_bucket_histogram.sv =====
// Self-checking stream testbench for log_bucket_histogram with a shadow histogram.
module tb_log_bucket_histogram;

  timeunit 1ns;
  timeprecision 1ps;

  import lbh_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    logic [BKT_W-1:0] bnum;
    logic [VAL_W-1:0] tally;
    logic [VAL_W-1:0] cnt;
    logic [VAL_W-1:0] sum;
    logic [VAL_W-1:0] mn;
    logic [VAL_W-1:0] mx;
    logic [VAL_W-1:0] over;
  } hist_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // sample, bucket_index, zero pad
  logic                  in_tuser = 1'b0; // opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // bucket_number, bucket_tally, sample_count, sample_sum, smallest, largest,
  // over_limit_count, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [VAL_W-1:0]      cfg_wdata = '0;

  // shadow histogram and its registers
  logic [VAL_W-1:0] sh_counters [NCNT];
  logic [VAL_W-1:0] sh_count = '0;
  logic [VAL_W-1:0] sh_sum = '0;
  logic [VAL_W-1:0] sh_min = ALL_ONES;
  logic [VAL_W-1:0] sh_max = '0;
  logic [VAL_W-1:0] sh_over = '0;
  logic             sh_log = 1'b0;
  logic [BKT_W-1:0] sh_buckets = '0;
  logic [VAL_W-1:0] sh_limit = '0;

  hist_report_t report_q [$];
  int err_count = 0;
  int cycle_count = 0;

  // sender pacing and receiver stalls
  int burst_left = 1;
  int burst_max = 8;
  int gap_max = 4;
  stall_mode_t stall_mode = STALL_RANDOM;
  int stall_pct = 30;
  int hold_req = 0;
  int hold_cnt = 0;
  int period_cnt = 0;

  log_bucket_histogram u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_log_bucket_histogram: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    period_cnt = (period_cnt + 1) % 7;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE: out_tready <= 1'b1;
        STALL_RANDOM: out_tready <= ($urandom_range(0, 99) >= stall_pct);
        default: out_tready <= (period_cnt > 2);
      endcase
    end
  end

  function automatic logic [BKT_W-1:0] select_bucket(logic [VAL_W-1:0] s);
    int n;
    int k;
    n = (sh_buckets > NREG) ? NREG : int'(sh_buckets);
    k = 0;
    if (sh_log && n > LIN_MAX) begin
      for (int i = 1; i <= n; i++)
        if (BOUNDS[i] <= s) k++;
    end else begin
      k = (s < 64'(n)) ? int'(s) : n;
    end
    return BKT_W'(k);
  endfunction

  task automatic tally_item(logic op, logic [VAL_W-1:0] smp, logic [BKT_W-1:0] idx);
    hist_report_t r;
    if (op == OP_ENTER) begin
      r.bnum = select_bucket(smp);
      sh_counters[r.bnum] += 1;
      r.tally = sh_counters[r.bnum];
      sh_count += 1;
      sh_sum += smp;
      if (sh_limit != 0 && smp > sh_limit) sh_over += 1;
      if (smp > sh_max) sh_max = smp;
      if (smp < sh_min) sh_min = smp;
    end else begin
      r.bnum = idx;
      r.tally = (idx < NCNT) ? sh_counters[idx] : '0;
    end
    r.cnt = sh_count;
    r.sum = sh_sum;
    r.mn = sh_min;
    r.mx = sh_max;
    r.over = sh_over;
    report_q.push_back(r);
  endtask

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    hist_report_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (report_q.size() == 0) begin
        $error("result item with nothing expected");
        err_count++;
      end else begin
        want = report_q.pop_front();
        check_field("bucket_number", 64'(want.bnum), 64'(out_tdata[6:0]));
        check_field("bucket_tally", want.tally, out_tdata[70:7]);
        check_field("sample_count", want.cnt, out_tdata[134:71]);
        check_field("sample_sum", want.sum, out_tdata[198:135]);
        check_field("smallest", want.mn, out_tdata[262:199]);
        check_field("largest", want.mx, out_tdata[326:263]);
        check_field("over_limit_count", want.over, out_tdata[390:327]);
      end
    end
  end

  task automatic send_item(logic op, logic [VAL_W-1:0] smp, logic [BKT_W-1:0] idx);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, idx, smp};
    do @(posedge clk); while (in_tready !== 1'b1);
    tally_item(op, smp, idx);
    burst_left--;
    if (gap_max > 0 && burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, burst_max);
    end
  endtask

  task automatic enter(logic [VAL_W-1:0] smp);
    send_item(OP_ENTER, smp, BKT_W'($urandom));
  endtask

  task automatic read_bucket(logic [BKT_W-1:0] idx);
    send_item(OP_READ, {$urandom, $urandom}, idx);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_LOG_SCALE: sh_log = val[0];
      REG_BUCKETS: sh_buckets = val[BKT_W-1:0];
      REG_SAMPLE_LIMIT: begin
        sh_limit = val;
        sh_over = '0;
      end
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_sample();
    logic [VAL_W-1:0] s;
    case ($urandom_range(0, 7))
      0: s = 64'($urandom_range(0, 130));
      1, 2: s = BOUNDS[$urandom_range(0, NBOUNDS - 1)] + 64'($urandom_range(0, 2)) - 64'd1;
      3: s = {$urandom, $urandom};
      4: s = {$urandom, $urandom} >> $urandom_range(0, 63);
      5: begin
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = ALL_ONES;
          2: s = BOUNDS[NBOUNDS - 1];
          default: s = BOUNDS[NBOUNDS - 1] + 64'd1;
        endcase
      end
      default: s = {$urandom, $urandom} % 64'd2000000000000;
    endcase
    return s;
  endfunction

  // defaults after reset: zero buckets, everything lands in bucket 0
  task automatic test_after_reset();
    read_bucket(7'd0);
    read_bucket(7'd127);
    enter(ALL_ONES);
    wait_drain();
  endtask

  task automatic test_linear();
    write_reg(REG_LOG_SCALE, 64'd0);
    write_reg(REG_BUCKETS, 64'd10);
    enter(64'd0);
    enter(64'd9);
    enter(64'd10);
    enter(64'd11);
    enter(64'h8000_0000_0000_0000);
    read_bucket(7'd10);
    wait_drain();
  endtask

  task automatic test_log();
    write_reg(REG_LOG_SCALE, 64'd1);
    write_reg(REG_BUCKETS, 64'd120);
    enter(64'd11);
    enter(64'd12);
    enter(64'd999999999999);
    enter(64'd1000000000000);
    enter(ALL_ONES);
    wait_drain();
    // bucket count above the store saturates
    write_reg(REG_BUCKETS, 64'd127);
    enter(64'd125892541179);
    wait_drain();
    // ten buckets or fewer stay linear even with log selected
    write_reg(REG_BUCKETS, 64'd10);
    enter(64'd11);
    wait_drain();
  endtask

  task automatic test_limit();
    write_reg(REG_SAMPLE_LIMIT, 64'd100);
    enter(64'd100);
    enter(64'd101);
    wait_drain();
    write_reg(REG_SAMPLE_LIMIT, ALL_ONES);
    enter(ALL_ONES);
    wait_drain();
    write_reg(REG_SAMPLE_LIMIT, 64'd0);
    write_reg(REG_UNUSED, ALL_ONES);
    enter(64'd5);
    read_bucket(7'd5);
    wait_drain();
  endtask

  task automatic test_read_beyond();
    read_bucket(7'd121);
    read_bucket(7'd126);
    wait_drain();
  endtask

  task automatic test_random_phases();
    logic             lg;
    logic [BKT_W-1:0] nb;
    logic [VAL_W-1:0] lim;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin lg = 1'b1; nb = 7'd120; end
        1: begin lg = 1'b0; nb = 7'd0; end
        2: begin lg = 1'b1; nb = 7'd127; end
        3: begin lg = 1'b0; nb = 7'd120; end
        4: begin lg = 1'b1; nb = 7'd11; end
        5: begin lg = 1'b1; nb = 7'd10; end
        default: begin lg = 1'($urandom); nb = BKT_W'($urandom); end
      endcase
      case (ph % 4)
        0: lim = '0;
        1: lim = ALL_ONES;
        2: lim = BOUNDS[$urandom_range(0, NBOUNDS - 1)];
        default: lim = {$urandom, $urandom};
      endcase
      write_reg(REG_LOG_SCALE, {$urandom, $urandom} & ~64'd1 | 64'(lg));
      write_reg(REG_BUCKETS, {$urandom, $urandom} & ~64'h7f | 64'(nb));
      write_reg(REG_SAMPLE_LIMIT, lim);
      if (ph == 3) begin
        stall_mode = STALL_NONE;
        gap_max = 0;
      end else begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        stall_pct = $urandom_range(10, 60);
        gap_max = $urandom_range(1, 8);
        burst_max = $urandom_range(1, 20);
      end
      burst_left = 1;
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(0, 99) < 15) read_bucket(BKT_W'($urandom));
        else enter(rand_sample());
      end
      wait_drain();
    end
  endtask

  // long receiver hold-off while the sender keeps offering back to back
  task automatic test_backpressure();
    stall_mode = STALL_RANDOM;
    stall_pct = 20;
    gap_max = 0;
    hold_req = 200;
    for (int i = 0; i < 60; i++) begin
      if (i % 8 == 7) read_bucket(BKT_W'($urandom_range(0, NREG)));
      else enter(rand_sample());
    end
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < NCNT; i++) sh_counters[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_linear();
    test_log();
    test_limit();
    test_read_beyond();
    test_random_phases();
    test_backpressure();
    repeat (12) @(posedge clk);
    if (err_count == 0 && report_q.size() == 0) begin
      $display("tb_log_bucket_histogram: done, clean");
    end else begin
      $display("tb_log_bucket_histogram: done, errors");
    end
    $finish;
  end

endmodule
